### hdl/i2c_master_bit_sequencer_defines.svh
// Assertion macros shared by the checker of the I2C master bit sequencer.
// Requires a clock named clock and an active-high reset named reset in scope.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2CMS_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/i2cms_pkg.sv
// Package of the I2C master bit sequencer: phase encoding, command codes,
// register indexes, sequencer state and per-tick result types. No dependencies.
`default_nettype none

package i2cms_pkg;

   localparam int TpuWidth   = 10;
   localparam int LimitWidth = 8;

   localparam logic [TpuWidth-1:0]   TpuReset   = 10'd1;
   localparam logic [LimitWidth-1:0] LimitReset = 8'd250;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_TICKS_PER_UNIT = 1'b0,
      CSR_ACK_POLL_LIMIT = 1'b1
   } csr_index_type;

   // Command codes carried by an input transfer.
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_WAIT  = 3'd4,
      CMD_READ  = 3'd5
   } cmd_type;

   // Sequencer phase, one-hot.
   typedef enum logic [15:0] {
      PH_IDLE      = 16'h0001,
      PH_ST_SDA_LO = 16'h0002,
      PH_ST_END    = 16'h0004,
      PH_SP_RISE   = 16'h0008,
      PH_SP_END    = 16'h0010,
      PH_WA_HIGH   = 16'h0020,
      PH_WA_POLL   = 16'h0040,
      PH_WR_BIT    = 16'h0080,
      PH_WR_HIGH   = 16'h0100,
      PH_WR_LOW    = 16'h0200,
      PH_WR_END    = 16'h0400,
      PH_RD_LOW    = 16'h0800,
      PH_RD_HIGH   = 16'h1000,
      PH_AK_DRIVE  = 16'h2000,
      PH_AK_HIGH   = 16'h4000,
      PH_AK_LOW    = 16'h8000
   } phase_type;

   typedef struct packed {
      phase_type             phase;
      logic [2:0]            active_cmd;
      logic [3:0]            bit_index;
      logic [7:0]            shift_data;
      logic [TpuWidth-1:0]   delay_count;
      logic [2:0]            unit_count;
      logic [LimitWidth-1:0] poll_count;
      logic                  ack_choice;
      logic                  scl;
      logic                  sda;
      logic                  sda_en;
   } seq_state_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_enable;
      logic       busy;
      logic       done;
      logic [7:0] rx_byte;
      logic       ack_failed;
   } tick_result_type;

endpackage

`default_nettype wire

### hdl/i2c_master_bit_sequencer.sv
// I2C master bit sequencer, one input transfer per timing tick, one result transfer per tick.
// Top level: timing-unit registers, sequencer state and result register; uses i2cms_pkg
// and i2cms_step.
//
// Each input transfer is one tick of the bit timing. While the sequencer is idle, the tick
// may carry a command: start, stop, write a byte MSB first, wait for the slave ACK, or read
// a byte and answer with ACK or NACK. Commands given while busy, and unused codes, are
// ignored. Every tick yields exactly one result transfer with the SCL level, the SDA level
// and its output enable, busy, and a one-tick done flag; on done the received byte (read)
// or the ACK-failure flag (timed-out ACK wait, after which a stop has been sent) is valid,
// otherwise those fields are zero. Line changes are spaced in delay units of
// ticks_per_unit ticks (zero acts as one); an ACK wait polls sda_in once per tick and
// fails after ack_poll_limit plus one high polls. The block takes one tick in every
// clock cycle while the result is not stalled: the whole tick update is a single pass of
// combinational logic from the state registers into the result register, so a result
// appears in the cycle after its tick is accepted. The result register stands between
// the channels, so a new tick is accepted whenever the result register is empty or its
// result is taken in the same cycle. Configuration writes take effect on the next tick
// and are meant for idle times. After reset the lines read SCL high, SDA high and driven,
// with ticks_per_unit at one and ack_poll_limit at 250.
`default_nettype none

module i2c_master_bit_sequencer
   import i2cms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [TpuWidth-1:0]   csr_write_data,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0]            req_cmd,
   input  logic [7:0]            req_tx_byte,
   input  logic                  req_send_ack,
   input  logic                  req_sda_in,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_level,
   output logic                  rsp_sda_enable,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic [7:0]            rsp_rx_byte,
   output logic                  rsp_ack_failed
);

   logic [TpuWidth-1:0]   tpu_ff;
   logic [LimitWidth-1:0] limit_ff;

   seq_state_type         state_ff;
   seq_state_type         state_in;
   tick_result_type       result_ff;
   tick_result_type       result_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  req_fire;

   // Configuration registers, written by index.
   always_ff @(posedge clock) begin
      if (reset) begin
         tpu_ff   <= TpuReset;
         limit_ff <= LimitReset;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICKS_PER_UNIT: tpu_ff   <= csr_write_data;
            CSR_ACK_POLL_LIMIT: limit_ff <= csr_write_data[LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   // A tick is taken when the result register is free or being emptied now.
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;

   i2cms_step u_step (
      .state_cur      (state_ff),
      .cmd            (req_cmd),
      .tx_byte        (req_tx_byte),
      .send_ack       (req_send_ack),
      .sda_in         (req_sda_in),
      .ticks_per_unit (tpu_ff),
      .ack_poll_limit (limit_ff),
      .state_next     (state_in),
      .result         (result_in)
   );

   assign rsp_valid_in = req_fire | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.active_cmd  <= 3'd0;
         state_ff.bit_index   <= 4'd0;
         state_ff.shift_data  <= 8'd0;
         state_ff.delay_count <= '0;
         state_ff.unit_count  <= 3'd0;
         state_ff.poll_count  <= '0;
         state_ff.ack_choice  <= 1'b0;
         state_ff.scl         <= 1'b1;
         state_ff.sda         <= 1'b1;
         state_ff.sda_en      <= 1'b1;
         rsp_valid_ff         <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // Result payload needs no reset; it is only looked at while valid.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_level  = result_ff.scl_level;
   assign rsp_sda_level  = result_ff.sda_level;
   assign rsp_sda_enable = result_ff.sda_enable;
   assign rsp_busy_res   = result_ff.busy;
   assign rsp_done_res   = result_ff.done;
   assign rsp_rx_byte    = result_ff.rx_byte;
   assign rsp_ack_failed = result_ff.ack_failed;

endmodule

`default_nettype wire

### hdl/i2cms_step.sv
// Next-state and result logic for one tick of the I2C master bit sequencer.
// Purely combinational; depends on i2cms_pkg.
`default_nettype none

module i2cms_step
   import i2cms_pkg::*;
(
   input  seq_state_type          state_cur,
   input  logic [2:0]             cmd,
   input  logic [7:0]             tx_byte,
   input  logic                   send_ack,
   input  logic                   sda_in,
   input  logic [TpuWidth-1:0]    ticks_per_unit,
   input  logic [LimitWidth-1:0]  ack_poll_limit,
   output seq_state_type          state_next,
   output tick_result_type        result
);

   logic [TpuWidth-1:0] tpu_eff;
   seq_state_type       t;
   logic                do_act;
   logic                fin;
   logic                fin_fail;
   logic [7:0]          fin_rx;
   logic [3:0]          bi_next;

   assign tpu_eff = (ticks_per_unit == '0) ? TpuWidth'(1) : ticks_per_unit;

   always_comb begin
      t        = state_cur;
      do_act   = 1'b0;
      fin      = 1'b0;
      fin_fail = 1'b0;
      fin_rx   = 8'd0;
      bi_next  = 4'(state_cur.bit_index + 4'd1);

      // Command acceptance, delay countdown or immediate action.
      if (state_cur.phase == PH_IDLE) begin
         if (cmd >= CMD_START && cmd <= CMD_READ) begin
            t.active_cmd = cmd;
            t.bit_index  = 4'd0;
            t.poll_count = '0;
            unique case (cmd)
               CMD_START: begin
                  t.sda_en = 1'b1; t.sda = 1'b1; t.scl = 1'b1;
                  t.delay_count = tpu_eff; t.unit_count = 3'd4; t.phase = PH_ST_SDA_LO;
               end
               CMD_STOP: begin
                  t.sda_en = 1'b1; t.scl = 1'b0; t.sda = 1'b0;
                  t.delay_count = tpu_eff; t.unit_count = 3'd4; t.phase = PH_SP_RISE;
               end
               CMD_WRITE: begin
                  t.sda_en = 1'b1; t.scl = 1'b0;
                  t.shift_data = tx_byte;
                  t.phase = PH_WR_BIT;
                  do_act = 1'b1;
               end
               CMD_WAIT: begin
                  t.sda_en = 1'b0; t.sda = 1'b1;
                  t.delay_count = tpu_eff; t.unit_count = 3'd1; t.phase = PH_WA_HIGH;
               end
               default: begin
                  t.sda_en = 1'b0;
                  t.ack_choice = send_ack;
                  t.shift_data = 8'd0;
                  t.phase = PH_RD_LOW;
                  do_act = 1'b1;
               end
            endcase
         end
      end else if (state_cur.unit_count != 3'd0) begin
         t.delay_count = TpuWidth'(state_cur.delay_count - TpuWidth'(1));
         if (t.delay_count == '0) begin
            t.unit_count = 3'(state_cur.unit_count - 3'd1);
            if (t.unit_count == 3'd0) begin
               do_act = 1'b1;
            end else begin
               t.delay_count = tpu_eff;
            end
         end
      end else begin
         do_act = 1'b1;
      end

      // Line action of the current phase.
      if (do_act) begin
         bi_next = 4'(t.bit_index + 4'd1);
         unique case (t.phase)
            PH_ST_SDA_LO: begin
               t.sda = 1'b0;
               t.delay_count = tpu_eff; t.unit_count = 3'd4; t.phase = PH_ST_END;
            end
            PH_ST_END: begin
               t.scl = 1'b0;
               fin = 1'b1;
            end
            PH_SP_RISE: begin
               t.scl = 1'b1; t.sda = 1'b1;
               t.delay_count = tpu_eff; t.unit_count = 3'd4; t.phase = PH_SP_END;
            end
            PH_SP_END: begin
               fin_fail = (t.active_cmd == CMD_WAIT);
               fin = 1'b1;
            end
            PH_WA_HIGH: begin
               t.scl = 1'b1;
               t.delay_count = tpu_eff; t.unit_count = 3'd1; t.phase = PH_WA_POLL;
            end
            PH_WA_POLL: begin
               t.unit_count = 3'd0;
               priority if (!sda_in) begin
                  t.scl = 1'b0;
                  fin = 1'b1;
               end else if (t.poll_count >= ack_poll_limit) begin
                  // Timeout: issue a stop condition, reported as a failure at its end.
                  t.sda_en = 1'b1; t.scl = 1'b0; t.sda = 1'b0;
                  t.delay_count = tpu_eff; t.unit_count = 3'd4; t.phase = PH_SP_RISE;
               end else begin
                  t.poll_count = LimitWidth'(t.poll_count + LimitWidth'(1));
               end
            end
            PH_WR_BIT: begin
               t.sda = t.shift_data[7];
               t.shift_data = {t.shift_data[6:0], 1'b0};
               t.delay_count = tpu_eff; t.unit_count = 3'd2; t.phase = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
               t.scl = 1'b1;
               t.delay_count = tpu_eff; t.unit_count = 3'd2; t.phase = PH_WR_LOW;
            end
            PH_WR_LOW: begin
               t.scl = 1'b0;
               t.bit_index = bi_next;
               t.delay_count = tpu_eff; t.unit_count = 3'd2;
               t.phase = (bi_next < 4'd8) ? PH_WR_BIT : PH_WR_END;
            end
            PH_RD_LOW: begin
               t.scl = 1'b0;
               t.delay_count = tpu_eff; t.unit_count = 3'd2; t.phase = PH_RD_HIGH;
            end
            PH_RD_HIGH: begin
               t.scl = 1'b1;
               t.shift_data = {t.shift_data[6:0], sda_in};
               t.bit_index = bi_next;
               t.delay_count = tpu_eff; t.unit_count = 3'd1;
               t.phase = (bi_next < 4'd8) ? PH_RD_LOW : PH_AK_DRIVE;
            end
            PH_AK_DRIVE: begin
               t.scl = 1'b0; t.sda_en = 1'b1; t.sda = ~t.ack_choice;
               t.delay_count = tpu_eff; t.unit_count = 3'd2; t.phase = PH_AK_HIGH;
            end
            PH_AK_HIGH: begin
               t.scl = 1'b1;
               t.delay_count = tpu_eff; t.unit_count = 3'd2; t.phase = PH_AK_LOW;
            end
            PH_AK_LOW: begin
               t.scl = 1'b0;
               fin_rx = t.shift_data;
               fin = 1'b1;
            end
            default: begin
               fin = 1'b1;
            end
         endcase
         if (fin) begin
            t.phase = PH_IDLE;
            t.unit_count = 3'd0;
            t.delay_count = '0;
         end
      end

      state_next = t;
   end

   assign result.scl_level  = t.scl;
   assign result.sda_level  = t.sda;
   assign result.sda_enable = t.sda_en;
   assign result.busy       = (t.phase != PH_IDLE);
   assign result.done       = fin;
   assign result.rx_byte    = fin_rx;
   assign result.ack_failed = fin_fail;

endmodule

`default_nettype wire

### hdl/i2cms_checker.sv
// Port-level checker of the I2C master bit sequencer, bound to the top level.
// Uses the assertion macros of i2c_master_bit_sequencer_defines.svh.
`default_nettype none
`include "i2c_master_bit_sequencer_defines.svh"

module i2cms_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_scl_level,
   input logic                  rsp_sda_level,
   input logic                  rsp_sda_enable,
   input logic                  rsp_busy_res,
   input logic                  rsp_done_res,
   input logic [7:0]            rsp_rx_byte,
   input logic                  rsp_ack_failed
);

   // A completed sequence leaves the sequencer idle.
   `I2CMS_ASSERT_IMPL(a_done_not_busy, rsp_valid && rsp_done_res, !rsp_busy_res, "done while busy")

   // The received byte is only shown on a completion tick.
   `I2CMS_ASSERT_IMPL(a_rx_only_on_done, rsp_valid && !rsp_done_res, rsp_rx_byte == 8'd0, "rx byte without done")

   // A failed ACK wait ends with the stop condition on the lines.
   `I2CMS_ASSERT_IMPL(a_fail_after_stop, rsp_valid && rsp_ack_failed, rsp_done_res && rsp_scl_level && rsp_sda_level && rsp_sda_enable, "ack failure without stop")

   // A stalled result stays offered with the same done flag and received byte.
   `I2CMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rx_byte) && $stable(rsp_done_res), "stalled result changed")

endmodule

bind i2c_master_bit_sequencer i2cms_checker u_i2cms_checker (.*);

`default_nettype wire
